// ----- rtl/igcd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package igcd_pkg;

    // Field widths fixed by the stream format
    localparam int PIXEL_W        = 8;
    localparam int GRAD_W         = 8;
    localparam int FRAME_WIDTH_W  = 12;
    localparam int FRAME_HEIGHT_W = 16;
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 16;

    // Register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // Register values after reset
    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd480;

    // Smallest usable frame height
    localparam logic [FRAME_HEIGHT_W-1:0] MIN_HEIGHT = 16'd3;

    // One gradient result
    typedef struct packed {
        logic signed [GRAD_W-1:0] vert_grad;
        logic signed [GRAD_W-1:0] horiz_grad;
        logic                     run_last;
        logic                     frame_end;
    } grad_result_t;

    // Halve both operands (floored), then subtract, modulo 256
    function automatic logic signed [GRAD_W-1:0] half_diff(
        input logic [PIXEL_W-1:0] hi,
        input logic [PIXEL_W-1:0] lo
    );
        logic [PIXEL_W-1:0] diff;
        diff = {1'b0, hi[PIXEL_W-1:1]} - {1'b0, lo[PIXEL_W-1:1]};
        return $signed(diff);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/igcd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Pixel request channel
interface igcd_pixel_if;
    import igcd_pkg::*;
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// Gradient result channel
interface igcd_grad_if;
    import igcd_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [GRAD_W-1:0] vert_grad;
    logic signed [GRAD_W-1:0] horiz_grad;
    logic                     run_last;
    logic                     frame_end;

    modport source (output valid, output vert_grad, output horiz_grad, output run_last,
                    output frame_end, input ready);
    modport sink   (input valid, input vert_grad, input horiz_grad, input run_last,
                    input frame_end, output ready);
endinterface

// Register write channel
interface igcd_cfg_if;
    import igcd_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/image_gradient_central_diff_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Timing: the result for a pixel of row r-1 is offered in the cycle after the pixel below it
//   is accepted; on the last row a result enters the buffer when the pixel to its right is.
// Throughput: one pixel per cycle while the result channel keeps up; on the last row a pixel
//   waits until the result buffer has drained to at most one result, the buffer giving up
//   one result per transfer. Reset: counters, pixel history and result count clear, registers
//   return to 640 x 480; the two line stores are not cleared and need no clearing pass.

module image_gradient_central_diff_unit #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic               clk,
    input  logic               rst_n,
    igcd_pixel_if.sink         pixels,
    igcd_grad_if.source        grads,
    igcd_cfg_if.sink           cfg
);
    import igcd_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WC_W  = (COL_W + 1 > FRAME_WIDTH_W) ? COL_W + 1 : FRAME_WIDTH_W;
    localparam logic [WC_W-1:0]  MAX_W_C   = WC_W'(MAX_WIDTH);
    localparam logic [WC_W-1:0]  MIN_W_C   = WC_W'(2);
    localparam logic [COL_W-1:0] LAST_ADDR = COL_W'(MAX_WIDTH - 1);

    // Configuration registers
    logic [FRAME_WIDTH_W-1:0]  frame_width_reg;
    logic [FRAME_HEIGHT_W-1:0] frame_height_reg;

    // Position and pixel history
    logic [COL_W-1:0]          col_reg, col_next;
    logic [FRAME_HEIGHT_W-1:0] row_reg, row_cnt_next;
    logic [PIXEL_W-1:0]        prev_pix_reg;
    logic [PIXEL_W-1:0]        two_back_reg;
    logic [PIXEL_W-1:0]        recent_zero_reg;
    logic [PIXEL_W-1:0]        right_prev_reg;
    logic [PIXEL_W-1:0]        centre_prev_reg;

    // Line stores and their registered read data
    logic [PIXEL_W-1:0]        older_mem  [MAX_WIDTH];
    logic [PIXEL_W-1:0]        recent_mem [MAX_WIDTH];
    logic [PIXEL_W-1:0]        older_rd_reg;
    logic [PIXEL_W-1:0]        recent_rd_reg;
    logic [COL_W-1:0]          older_raddr;
    logic [COL_W-1:0]          recent_raddr;

    // Result buffer
    grad_result_t              slot_reg  [3];
    grad_result_t              slot_next [3];
    grad_result_t              new_slot  [3];
    logic [1:0]                cnt_reg, cnt_next, new_cnt;

    logic                      accept;
    logic                      pop;
    logic [WC_W-1:0]           width_ext;
    logic [WC_W-1:0]           w_eff;
    logic [FRAME_HEIGHT_W-1:0] h_eff;
    logic                      last_col;
    logic                      last_row;
    logic [PIXEL_W-1:0]        px;
    logic [PIXEL_W-1:0]        centre;
    logic [PIXEL_W-1:0]        right;
    logic [PIXEL_W-1:0]        above;
    logic [PIXEL_W-1:0]        left;
    logic                      has_a, has_b, has_c;
    grad_result_t              res_a, res_b, res_c;

    // Handshakes
    assign accept       = pixels.valid && pixels.ready;
    assign pop          = grads.valid && grads.ready;
    assign pixels.ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && grads.ready);
    assign cfg.ready    = 1'b1;

    // Clamp frame size and find the frame edges
    always_comb
    begin
        width_ext = WC_W'(frame_width_reg);
        if (width_ext < MIN_W_C)
            w_eff = MIN_W_C;
        else if (width_ext > MAX_W_C)
            w_eff = MAX_W_C;
        else
            w_eff = width_ext;
        h_eff    = (frame_height_reg < MIN_HEIGHT) ? MIN_HEIGHT : frame_height_reg;
        last_col = WC_W'(col_reg) >= (w_eff - WC_W'(1));
        last_row = row_reg >= (h_eff - FRAME_HEIGHT_W'(1));
    end

    // Next position and prefetch addresses for the next request
    always_comb
    begin
        col_next     = last_col ? '0 : col_reg + COL_W'(1);
        row_cnt_next = row_reg;
        if (last_col)
            row_cnt_next = last_row ? '0 : row_reg + FRAME_HEIGHT_W'(1);
        older_raddr  = col_next;
        recent_raddr = (col_next == LAST_ADDR) ? '0 : col_next + COL_W'(1);
    end

    // Neighbourhood of the pixel one row up
    assign px     = pixels.pixel;
    assign centre = (col_reg == '0) ? recent_zero_reg : right_prev_reg;
    assign right  = recent_rd_reg;
    assign above  = older_rd_reg;
    assign left   = centre_prev_reg;

    // Line stores: write this column, read ahead for the next, forward on a clash
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            older_mem[col_reg]  <= centre;
            recent_mem[col_reg] <= px;
            if (older_raddr == col_reg)
                older_rd_reg <= centre;
            else
                older_rd_reg <= older_mem[older_raddr];
            if (recent_raddr == col_reg)
                recent_rd_reg <= px;
            else
                recent_rd_reg <= recent_mem[recent_raddr];
        end
    end

    // Form the results caused by this request
    always_comb
    begin
        has_a = row_reg != '0;
        has_b = last_row && (col_reg != '0);
        has_c = last_row && last_col;

        // Pixel one row up
        res_a.vert_grad = (row_reg == FRAME_HEIGHT_W'(1)) ? half_diff(px, centre)
                                                          : half_diff(px, above);
        if (col_reg == '0)
            res_a.horiz_grad = half_diff(right, centre);
        else if (last_col)
            res_a.horiz_grad = half_diff(centre, left);
        else
            res_a.horiz_grad = half_diff(right, left);
        res_a.run_last  = !has_b && !has_c;
        res_a.frame_end = 1'b0;

        // Previous pixel of the last row
        res_b.vert_grad  = half_diff(prev_pix_reg, left);
        res_b.horiz_grad = (col_reg == COL_W'(1)) ? half_diff(px, prev_pix_reg)
                                                  : half_diff(px, two_back_reg);
        res_b.run_last   = !has_c;
        res_b.frame_end  = 1'b0;

        // Final pixel of the frame
        res_c.vert_grad  = half_diff(px, centre);
        res_c.horiz_grad = half_diff(px, prev_pix_reg);
        res_c.run_last   = 1'b1;
        res_c.frame_end  = 1'b1;

        // Pack present results to the front
        new_cnt = 2'(has_a) + 2'(has_b) + 2'(has_c);
        priority if (has_a)
            new_slot[0] = res_a;
        else if (has_b)
            new_slot[0] = res_b;
        else
            new_slot[0] = res_c;
        new_slot[1] = (has_a && has_b) ? res_b : res_c;
        new_slot[2] = res_c;
    end

    // Advance the result buffer: drop the head on a pop, load on a request
    always_comb
    begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (pop)
        begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            cnt_next     = cnt_reg - 2'd1;
        end
        if (accept)
        begin
            slot_next = new_slot;
            cnt_next  = new_cnt;
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg          <= 2'd0;
            col_reg          <= '0;
            row_reg          <= '0;
            prev_pix_reg     <= '0;
            two_back_reg     <= '0;
            recent_zero_reg  <= '0;
            right_prev_reg   <= '0;
            centre_prev_reg  <= '0;
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (accept)
            begin
                col_reg         <= col_next;
                row_reg         <= row_cnt_next;
                prev_pix_reg    <= px;
                two_back_reg    <= prev_pix_reg;
                right_prev_reg  <= recent_rd_reg;
                centre_prev_reg <= centre;
                if (col_reg == '0)
                    recent_zero_reg <= px;
            end
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    CFG_FRAME_WIDTH:  frame_width_reg  <= cfg.data[FRAME_WIDTH_W-1:0];
                    CFG_FRAME_HEIGHT: frame_height_reg <= cfg.data[FRAME_HEIGHT_W-1:0];
                endcase
            end
        end
    end

    // Drive the result channel from the buffer head
    assign grads.valid      = cnt_reg != 2'd0;
    assign grads.vert_grad  = slot_reg[0].vert_grad;
    assign grads.horiz_grad = slot_reg[0].horiz_grad;
    assign grads.run_last   = slot_reg[0].run_last;
    assign grads.frame_end  = slot_reg[0].frame_end;

endmodule

`default_nettype wire

// ----- tb/image_gradient_central_diff_unit_tb.sv -----
`timescale 1ns / 1ps

module image_gradient_central_diff_unit_tb;
    import igcd_pkg::*;

    localparam int MAX_W         = 2048;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 2000;

    logic clk = 1'b0;
    logic rst_n;

    igcd_pixel_if pixel_ch ();
    igcd_grad_if  grad_ch ();
    igcd_cfg_if   cfg_ch ();

    image_gradient_central_diff_unit #(
        .MAX_WIDTH(MAX_W)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixels (pixel_ch),
        .grads  (grad_ch),
        .cfg    (cfg_ch)
    );

    // Shadow of the block: registers, line stores, counters and pixel history
    logic [FRAME_WIDTH_W-1:0]  width_reg  = FRAME_WIDTH_RST;
    logic [FRAME_HEIGHT_W-1:0] height_reg = FRAME_HEIGHT_RST;
    logic [PIXEL_W-1:0]        older_row  [MAX_W];
    logic [PIXEL_W-1:0]        recent_row [MAX_W];
    int unsigned               col_cnt    = 0;
    int unsigned               row_cnt    = 0;
    logic [PIXEL_W-1:0]        prev_px    = '0;
    logic [PIXEL_W-1:0]        prev2_px   = '0;

    grad_result_t pending_grads [$];

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int mismatches    = 0;
    int pixels_taken  = 0;
    int grads_checked = 0;
    int frames_closed = 0;
    int cfg_writes    = 0;
    int quiet_cycles  = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < MAX_W; i++)
        begin
            older_row[i]  = '0;
            recent_row[i] = '0;
        end
    end

    // Floor both halves, then subtract modulo 256
    function automatic logic signed [GRAD_W-1:0] halved_step(input logic [PIXEL_W-1:0] hi,
                                                             input logic [PIXEL_W-1:0] lo);
        logic [PIXEL_W-1:0] a;
        logic [PIXEL_W-1:0] b;
        a = hi >> 1;
        b = lo >> 1;
        return $signed(a - b);
    endfunction

    // Work out the gradients that one accepted pixel releases, and advance the shadow
    task automatic predict_gradients(input logic [PIXEL_W-1:0] px);
        int unsigned        w;
        int unsigned        h;
        int unsigned        c;
        int                 n;
        bit                 last_col;
        bit                 last_row;
        logic [PIXEL_W-1:0] above_old;
        logic [PIXEL_W-1:0] centre_old;
        logic [PIXEL_W-1:0] right_old;
        logic [PIXEL_W-1:0] left_old;
        grad_result_t       batch [3];
        w = width_reg;
        h = height_reg;
        c = col_cnt;
        n = 0;
        if (w < 2)
            w = 2;
        if (w > MAX_W)
            w = MAX_W;
        if (h < 3)
            h = 3;
        if (c >= MAX_W)
            c = MAX_W - 1;
        last_col = (c >= w - 1);
        last_row = (row_cnt >= h - 1);

        above_old  = older_row[c];
        centre_old = recent_row[c];
        right_old  = last_col ? '0 : recent_row[c + 1];
        left_old   = (c >= 1) ? older_row[c - 1] : '0;
        older_row[c]  = centre_old;
        recent_row[c] = px;

        // Pixel one row up from the current one
        if (row_cnt >= 1)
        begin
            batch[n] = '0;
            batch[n].vert_grad = halved_step(px, (row_cnt == 1) ? centre_old : above_old);
            if (c == 0)
                batch[n].horiz_grad = halved_step(right_old, centre_old);
            else if (last_col)
                batch[n].horiz_grad = halved_step(centre_old, left_old);
            else
                batch[n].horiz_grad = halved_step(right_old, left_old);
            n++;
        end

        // Bottom row lags one pixel: emit the one to the left
        if (last_row && c >= 1)
        begin
            batch[n] = '0;
            batch[n].vert_grad  = halved_step(prev_px, older_row[c - 1]);
            batch[n].horiz_grad = halved_step(px, (c == 1) ? prev_px : prev2_px);
            n++;
        end

        // Final pixel of the frame flushes itself
        if (last_row && last_col)
        begin
            batch[n] = '0;
            batch[n].vert_grad  = halved_step(px, centre_old);
            batch[n].horiz_grad = halved_step(px, prev_px);
            batch[n].frame_end  = 1'b1;
            n++;
        end

        if (n > 0)
            batch[n - 1].run_last = 1'b1;
        for (int k = 0; k < n; k++)
            pending_grads.push_back(batch[k]);

        prev2_px = prev_px;
        prev_px  = px;
        if (last_col)
        begin
            col_cnt = 0;
            if (last_row)
                row_cnt = 0;
            else
                row_cnt = (row_cnt + 1) & 32'hFFFF;
        end
        else
        begin
            col_cnt = c + 1;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Record each accepted pixel request
    always @(posedge clk)
    begin
        if (rst_n && pixel_ch.valid && pixel_ch.ready)
        begin
            pixels_taken++;
            predict_gradients(pixel_ch.pixel);
        end
    end

    // Compare each accepted gradient with the oldest prediction
    always @(posedge clk)
    begin : check_grads
        grad_result_t want;
        if (rst_n && grad_ch.valid && grad_ch.ready)
        begin
            grads_checked++;
            if (grad_ch.frame_end === 1'b1)
                frames_closed++;
            if (pending_grads.size() == 0)
            begin
                report_mismatch($sformatf("unexpected gradient v=%0d h=%0d",
                                          grad_ch.vert_grad, grad_ch.horiz_grad));
            end
            else
            begin
                want = pending_grads.pop_front();
                if (grad_ch.vert_grad !== want.vert_grad)
                    report_mismatch($sformatf("vert_grad %0d, want %0d",
                                              grad_ch.vert_grad, want.vert_grad));
                if (grad_ch.horiz_grad !== want.horiz_grad)
                    report_mismatch($sformatf("horiz_grad %0d, want %0d",
                                              grad_ch.horiz_grad, want.horiz_grad));
                if (grad_ch.run_last !== want.run_last)
                    report_mismatch($sformatf("run_last %b, want %b",
                                              grad_ch.run_last, want.run_last));
                if (grad_ch.frame_end !== want.frame_end)
                    report_mismatch($sformatf("frame_end %b, want %b",
                                              grad_ch.frame_end, want.frame_end));
            end
        end
    end

    // Stall the result channel at the chosen rate
    always @(negedge clk)
        grad_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);

    // Abort if no channel moves for too long
    always @(posedge clk)
    begin
        if ((pixel_ch.valid && pixel_ch.ready) || (grad_ch.valid && grad_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic logic [PIXEL_W-1:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            default: return PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one pixel request, with random gaps ahead of it
    task automatic send_pixel(input logic [PIXEL_W-1:0] value);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            pixel_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pixel_ch.valid <= 1'b1;
        pixel_ch.pixel <= value;
        do
            @(posedge clk);
        while (!pixel_ch.ready);
    endtask

    // Drop valid, wait for every predicted gradient, then let the pipeline settle
    task automatic drain_results();
        @(negedge clk);
        pixel_ch.valid <= 1'b0;
        while (pending_grads.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == CFG_FRAME_WIDTH)
            width_reg = value[FRAME_WIDTH_W-1:0];
        else
            height_reg = value[FRAME_HEIGHT_W-1:0];
        cfg_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Zero height clamps to three rows; the nine-column frame also fills both
    // line stores across its nine columns
    task automatic test_store_fill();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        write_register(CFG_FRAME_WIDTH, 16'd9);
        write_register(CFG_FRAME_HEIGHT, 16'h0000);
        for (int i = 0; i < 27; i++)
            send_pixel(rand_pixel());
        drain_results();
    endtask

    // Smallest frame, then a three-column frame, with full-scale steps at every edge
    task automatic test_pixel_extremes();
        logic [PIXEL_W-1:0] tiny  [6]  = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0};
        logic [PIXEL_W-1:0] three [12] = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd0, 8'd255,
                                           8'd255, 8'd1, 8'd0, 8'd128, 8'd127, 8'd255};
        src_idle_pct  = 27;
        snk_stall_pct = 27;
        write_register(CFG_FRAME_WIDTH, 16'h0000);
        write_register(CFG_FRAME_HEIGHT, 16'h0002);
        foreach (tiny[i])
            send_pixel(tiny[i]);
        drain_results();
        write_register(CFG_FRAME_WIDTH, 16'h0003);
        write_register(CFG_FRAME_HEIGHT, 16'h0004);
        foreach (three[i])
            send_pixel(three[i]);
        drain_results();
    endtask

    // Shrink width past the column count, then height past the row count
    task automatic test_mid_frame_resize();
        src_idle_pct  = 27;
        snk_stall_pct = 27;
        write_register(CFG_FRAME_WIDTH, 16'd2048);
        write_register(CFG_FRAME_HEIGHT, 16'hFFFF);
        repeat (7) send_pixel(rand_pixel());
        drain_results();
        write_register(CFG_FRAME_WIDTH, 16'd4);
        repeat (10) send_pixel(rand_pixel());
        drain_results();
        write_register(CFG_FRAME_HEIGHT, 16'd3);
        repeat (3) send_pixel(rand_pixel());
        drain_results();
    endtask

    // Random geometry and pixels under one idling pattern
    task automatic test_random_stream(input int src_pct, input int snk_pct, input int count);
        logic [FRAME_WIDTH_W-1:0]  w;
        logic [FRAME_HEIGHT_W-1:0] h;
        drain_results();
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        w = ($urandom_range(0, 7) == 0) ? FRAME_WIDTH_W'($urandom_range(0, 1))
                                        : FRAME_WIDTH_W'($urandom_range(2, 9));
        case ($urandom_range(0, 7))
            0: h = FRAME_HEIGHT_W'($urandom_range(0, 2));
            1: h = 16'hFFFF;
            default: h = FRAME_HEIGHT_W'($urandom_range(3, 6));
        endcase
        write_register(CFG_FRAME_WIDTH, {4'($urandom_range(0, 15)), w});
        write_register(CFG_FRAME_HEIGHT, h);
        for (int k = 0; k < count; k++)
        begin
            // Hold the sender until the result stream has caught up
            if (k == count / 2 || $urandom_range(0, 15) == 0)
                drain_results();
            send_pixel(rand_pixel());
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        pixel_ch.valid = 1'b0;
        pixel_ch.pixel = '0;
        grad_ch.ready  = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_FRAME_WIDTH;
        cfg_ch.data    = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_store_fill();
        test_pixel_extremes();
        test_mid_frame_resize();
        test_random_stream(0, 0, 20);
        test_random_stream(72, 0, 16);
        test_random_stream(0, 72, 16);
        test_random_stream(27, 27, 16);
        drain_results();
        repeat (12) @(negedge clk);

        $display("Streamed %0d pixels over %0d register writes; %0d gradients checked.",
                 pixels_taken, cfg_writes, grads_checked);
        $display("Frames closed: %0d; field errors: %0d.", frames_closed, mismatches);
        if (mismatches == 0 && pending_grads.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
